// ===== design/spt_pkg.sv =====
// Shared constants, codes and types of the servo torque controller.
package spt_pkg;

    localparam int HISTORY_LEN        = 10;
    localparam bit TEMPERATURE_ENABLE = 1'b1;
    localparam int PTR_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;

    localparam int SET_W    = 17;
    localparam int ANG_W    = 16;
    localparam int ENERGY_W = 32;
    localparam int TORQUE_W = 32;
    localparam int TEMP_W   = 16;
    localparam int GAIN_W   = 32;
    localparam int RATE_W   = 16;
    localparam int FAULT_W  = 2;

    // error in degrees Q13.11, windowed sum, error delta, PID inner sum
    localparam int ERR_W   = 24;
    localparam int WS_W    = 30;
    localparam int DIFF_W  = 25;
    localparam int INNER_W = 62;
    localparam int MAG_W   = 61;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // 180/pi in Q16
    localparam logic signed [22:0] RAD_TO_DEG_Q16 = 23'sd3754936;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATING_RATE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING_RATE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TEMP     = 3'd7;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_ENERGY = 2'd1,
        FAULT_HEAT   = 2'd2
    } fault_t;

    typedef struct packed {
        logic rd;
        logic upd;
    } win_ctrl_t;

    typedef struct packed {
        logic [RATE_W-1:0] energy_factor;
        logic [RATE_W-1:0] heating_rate;
        logic [RATE_W-1:0] cooling_rate;
        logic [TEMP_W-1:0] failure_temperature;
    } pwr_cfg_t;

    typedef struct packed {
        logic [TORQUE_W-1:0] torque;
        logic [ENERGY_W-1:0] energy_out;
        logic [TEMP_W-1:0]   temp;
        fault_t              fault;
    } pwr_res_t;

endpackage

// ===== design/servo_pid_torque_thermal.sv =====
// Servo joint torque controller: windowed-integral PID, energy budget, thermal model.
//
// One input beat per control tick on s_*: desired setting, joint angle, battery level.
// One result beat per tick on m_*: torque, energy left, motor temperature, fault code.
// Registers are written through cfg_wr_en/cfg_index/cfg_wr_data; the user must write
// them only while idle, which the block itself does not enforce. Ticks are handled
// one at a time: s_tready rises in the same cycle as m_tvalid, so a new beat is
// accepted only once the last result is in the output register. In angle mode the
// time to a result is set by the chain of error history read-modify-write, the two
// gain multiplies, the proportional gain multiply split into two partial products,
// and the energy/thermal stage; in pass-through mode only by the energy/thermal stage.
// The error history is a small synchronous memory with per-entry valid bits.
// A result held in the output register does not block the next beat; if it is
// still not taken when the following result is ready, the block waits there.
// Reset (aresetn low, synchronous) restores the register defaults, empties the
// error window, clears the motor temperature and drops m_tvalid.
module servo_pid_torque_thermal (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // desired_setting[16:0], current_angle[32:17], energy_level[64:33], zero pad
    input  logic [spt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // torque[31:0], energy_level_out[63:32], motor_temperature[79:64], fault[81:80], pad
    output logic [spt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [spt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import spt_pkg::*;

    localparam int ANG_PROD_W = ANG_W + 23;
    localparam int ANG_SHIFT  = 17;
    localparam int ANG_DEG_W  = ANG_PROD_W - ANG_SHIFT;
    localparam int ANG_RND    = 65536;
    localparam int SET90_W    = SET_W + 8;
    localparam int DEG_SCALE  = 90;
    localparam int ERRF_W     = SET90_W + 1;
    localparam int P_I_W      = GAIN_W + WS_W;
    localparam int P_D_W      = GAIN_W + DIFF_W;
    localparam int M_PAD_W    = M_TDATA_W - TORQUE_W - ENERGY_W - TEMP_W - FAULT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_SUM, S_PROD, S_INNER, S_KPGO, S_KP, S_PASS, S_POWER, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic                     angle_mode_reg;
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    pwr_cfg_t                 pwr_cfg_reg;

    // tick datapath
    logic signed [SET_W-1:0]   setting_reg;
    logic signed [ANG_W-1:0]   angle_reg;
    logic [ENERGY_W-1:0]       energy_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [P_I_W-1:0]   p_i_reg;
    logic signed [P_D_W-1:0]   p_d_reg;
    logic signed [INNER_W-1:0] inner_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic                        s_accept;
    logic signed [ANG_PROD_W-1:0] ang_prod, ang_round;
    logic signed [ANG_DEG_W-1:0]  ang_deg;
    logic signed [SET90_W-1:0]    set90;
    logic signed [ERRF_W-1:0]     err_full;
    logic signed [DIFF_W-1:0]     err_diff;
    logic signed [WS_W-1:0]       window_sum;
    logic signed [TORQUE_W-1:0]   pass_torque, kp_torque, pow_torque;
    win_ctrl_t                    win_ctrl;
    logic                         kp_done, pow_start, pow_done, out_free, out_load;
    pwr_res_t                     pow_res;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_mode_reg                  <= 1'b1;
            kp_reg                          <= 32'sd65536;
            ki_reg                          <= '0;
            kd_reg                          <= '0;
            pwr_cfg_reg.energy_factor       <= 16'd66;
            pwr_cfg_reg.heating_rate        <= 16'd66;
            pwr_cfg_reg.cooling_rate        <= 16'd7;
            pwr_cfg_reg.failure_temperature <= 16'd58982;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ANGLE_MODE:    angle_mode_reg <= cfg_wr_data[0];
                CFG_KP:            kp_reg <= cfg_wr_data;
                CFG_KI:            ki_reg <= cfg_wr_data;
                CFG_KD:            kd_reg <= cfg_wr_data;
                CFG_ENERGY_FACTOR: pwr_cfg_reg.energy_factor <= cfg_wr_data[RATE_W-1:0];
                CFG_HEATING_RATE:  pwr_cfg_reg.heating_rate <= cfg_wr_data[RATE_W-1:0];
                CFG_COOLING_RATE:  pwr_cfg_reg.cooling_rate <= cfg_wr_data[RATE_W-1:0];
                CFG_FAIL_TEMP:     pwr_cfg_reg.failure_temperature <= cfg_wr_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // angle error in degrees, Q13.11
    assign ang_prod  = ANG_PROD_W'(angle_reg) * ANG_PROD_W'(RAD_TO_DEG_Q16);
    assign ang_round = ang_prod + ANG_PROD_W'(ANG_RND);
    assign ang_deg   = ANG_DEG_W'(ang_round >>> ANG_SHIFT);
    assign set90     = SET90_W'(setting_reg) * SET90_W'(DEG_SCALE);
    assign err_full  = ERRF_W'(set90) - ERRF_W'(ang_deg);
    assign err_diff  = DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);

    assign pass_torque = TORQUE_W'(setting_reg) <<< 4;

    assign win_ctrl.rd  = s_accept;
    assign win_ctrl.upd = (state_reg == S_SUM);

    spt_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (win_ctrl),
        .err_in     (err_reg),
        .window_sum (window_sum)
    );

    spt_kp_mul u_kp_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_KPGO),
        .kp      (kp_reg),
        .inner   (inner_reg),
        .done    (kp_done),
        .torque  (kp_torque)
    );

    assign pow_start  = (state_reg == S_PASS) || ((state_reg == S_KP) && kp_done);
    assign pow_torque = (state_reg == S_PASS) ? pass_torque : kp_torque;

    spt_power u_power (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pow_start),
        .torque_in (pow_torque),
        .energy_in (energy_reg),
        .cfg       (pwr_cfg_reg),
        .done      (pow_done),
        .res       (pow_res)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            setting_reg <= s_tdata[SET_W-1:0];
            angle_reg   <= s_tdata[SET_W+ANG_W-1:SET_W];
            energy_reg  <= s_tdata[SET_W+ANG_W+ENERGY_W-1:SET_W+ANG_W];
        end
        if (state_reg == S_ERR) begin
            err_reg <= ERR_W'(err_full);
        end
        if (state_reg == S_PROD) begin
            p_i_reg <= P_I_W'(ki_reg) * P_I_W'(window_sum);
            p_d_reg <= P_D_W'(kd_reg) * P_D_W'(err_diff);
        end
        if (state_reg == S_INNER) begin
            inner_reg <= (INNER_W'(err_reg) <<< 16) + INNER_W'(p_i_reg) + INNER_W'(p_d_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
        end else if (state_reg == S_PROD) begin
            prev_err_reg <= err_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (((state_reg == S_POWER) && pow_done) || (state_reg == S_OUT)) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_accept) state_next = angle_mode_reg ? S_ERR : S_PASS;
            S_ERR:   state_next = S_SUM;
            S_SUM:   state_next = S_PROD;
            S_PROD:  state_next = S_INNER;
            S_INNER: state_next = S_KPGO;
            S_KPGO:  state_next = S_KP;
            S_KP:    if (kp_done) state_next = S_POWER;
            S_PASS:  state_next = S_POWER;
            S_POWER: if (pow_done) state_next = out_free ? S_IDLE : S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{M_PAD_W{1'b0}}, pow_res.fault, pow_res.temp,
                                 pow_res.energy_out, pow_res.torque};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/spt_window.sv =====
// Error history memory with running window sum (read, modify, write back).
module spt_window (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  spt_pkg::win_ctrl_t               ctrl,
    input  logic signed [spt_pkg::ERR_W-1:0] err_in,
    output logic signed [spt_pkg::WS_W-1:0]  window_sum
);
    import spt_pkg::*;

    logic signed [ERR_W-1:0] hist_mem [HISTORY_LEN];
    logic signed [ERR_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic [HISTORY_LEN-1:0]  valid_reg;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic signed [WS_W-1:0]  ws_reg, ws_next;
    logic signed [ERR_W-1:0] old_err;

    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_data_reg <= hist_mem[ptr_reg];
        end
        if (ctrl.upd) begin
            hist_mem[ptr_reg] <= err_in;
        end
    end

    // entries never written read as zero
    assign old_err  = rd_valid_reg ? rd_data_reg : '0;
    assign ws_next  = ws_reg + WS_W'(err_in) - WS_W'(old_err);
    assign ptr_next = (ptr_reg == PTR_W'(HISTORY_LEN - 1)) ? '0 : ptr_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            valid_reg    <= '0;
            ws_reg       <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctrl.rd) begin
                rd_valid_reg <= valid_reg[ptr_reg];
            end
            if (ctrl.upd) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
                ws_reg             <= ws_next;
            end
        end
    end

    assign window_sum = ws_reg;

endmodule

// ===== design/spt_kp_mul.sv =====
// Proportional gain times PID inner sum: split multiply, rounding, saturation.
module spt_kp_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [spt_pkg::GAIN_W-1:0]   kp,
    input  logic signed [spt_pkg::INNER_W-1:0]  inner,
    output logic                                done,
    output logic signed [spt_pkg::TORQUE_W-1:0] torque
);
    import spt_pkg::*;

    localparam int LO_W   = 31;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = GAIN_W + LO_W;
    localparam int PHI_W  = GAIN_W + HI_W;
    localparam int PROD_W = GAIN_W + MAG_W;
    localparam int SHIFT  = 27;
    localparam int SH_W   = PROD_W - SHIFT;
    localparam logic [PROD_W-1:0] RND = PROD_W'(64'd1 << (SHIFT - 1));
    localparam logic [TORQUE_W-1:0] LIM_POS = {1'b0, {(TORQUE_W-1){1'b1}}};
    localparam logic [TORQUE_W-1:0] LIM_NEG = {1'b1, {(TORQUE_W-1){1'b0}}};

    typedef enum logic [2:0] {K_IDLE, K_LO, K_HI, K_SUM, K_SAT} kstate_t;

    kstate_t               state_reg;
    logic                  done_reg;
    logic [TORQUE_W-1:0]   torque_reg;
    logic [GAIN_W-1:0]     kpm_reg;
    logic [MAG_W-1:0]      im_reg;
    logic                  neg_reg;
    logic [PLO_W-1:0]      plo_reg;
    logic [PHI_W-1:0]      phi_reg;
    logic [SH_W-1:0]       sh_reg;

    logic [GAIN_W-1:0]     kp_mag;
    logic [INNER_W-1:0]    inner_neg;
    logic [MAG_W-1:0]      in_mag;
    logic [PROD_W-1:0]     prod_full;
    logic [TORQUE_W-1:0]   lim;
    logic [TORQUE_W-1:0]   sat_mag;

    assign kp_mag    = kp[GAIN_W-1] ? GAIN_W'(-kp) : GAIN_W'(kp);
    assign inner_neg = INNER_W'(-inner);
    assign in_mag    = inner[INNER_W-1] ? inner_neg[MAG_W-1:0] : inner[MAG_W-1:0];
    assign prod_full = {phi_reg, {LO_W{1'b0}}} + PROD_W'(plo_reg) + RND;
    assign lim       = neg_reg ? LIM_NEG : LIM_POS;
    assign sat_mag   = (sh_reg > SH_W'(lim)) ? lim : sh_reg[TORQUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= K_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                K_IDLE: begin
                    if (start) begin
                        kpm_reg   <= kp_mag;
                        im_reg    <= in_mag;
                        neg_reg   <= kp[GAIN_W-1] ^ inner[INNER_W-1];
                        state_reg <= K_LO;
                    end
                end
                K_LO: begin
                    plo_reg   <= PLO_W'(kpm_reg) * PLO_W'(im_reg[LO_W-1:0]);
                    state_reg <= K_HI;
                end
                K_HI: begin
                    phi_reg   <= PHI_W'(kpm_reg) * PHI_W'(im_reg[MAG_W-1:LO_W]);
                    state_reg <= K_SUM;
                end
                K_SUM: begin
                    sh_reg    <= SH_W'(prod_full >> SHIFT);
                    state_reg <= K_SAT;
                end
                K_SAT: begin
                    torque_reg <= neg_reg ? TORQUE_W'(-sat_mag) : sat_mag;
                    done_reg   <= 1'b1;
                    state_reg  <= K_IDLE;
                end
                default: state_reg <= K_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign torque = torque_reg;

endmodule

// ===== design/spt_power.sv =====
// Energy budget and motor thermal model; holds the motor temperature.
module spt_power (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [spt_pkg::TORQUE_W-1:0] torque_in,
    input  logic [spt_pkg::ENERGY_W-1:0]        energy_in,
    input  spt_pkg::pwr_cfg_t                   cfg,
    output logic                                done,
    output spt_pkg::pwr_res_t                   res
);
    import spt_pkg::*;

    localparam int MUL_W  = TORQUE_W + RATE_W + 1;
    localparam int TSUM_W = TORQUE_W + 2;
    localparam logic [MUL_W-1:0] HALF = MUL_W'(32768);

    typedef enum logic [1:0] {P_IDLE, P_MUL, P_EVAL} pstate_t;

    pstate_t             state_reg;
    logic                done_reg;
    pwr_res_t            res_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [TORQUE_W-1:0] amag_reg;
    logic [TORQUE_W-1:0] trq_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] use_reg;
    logic [TORQUE_W-1:0] rise_reg;

    logic [TORQUE_W-1:0] amag;
    logic [MUL_W-1:0]    use_full, rise_full;
    logic                short;
    logic                overheat;
    logic [TSUM_W-1:0]   heat_sum, heat_lim;
    logic [TEMP_W-1:0]   temp_norm, temp_cool, temp_new;
    fault_t              fault;

    assign amag      = torque_in[TORQUE_W-1] ? TORQUE_W'(-torque_in) : TORQUE_W'(torque_in);
    assign use_full  = MUL_W'(amag_reg) * MUL_W'(cfg.energy_factor) + HALF;
    assign rise_full = MUL_W'(amag_reg) * MUL_W'(cfg.heating_rate) + HALF;

    // factor 0 gives zero use, so the battery is never short then
    assign short     = energy_reg < use_reg;
    assign heat_sum  = TSUM_W'(temp_reg) + TSUM_W'(rise_reg);
    assign heat_lim  = TSUM_W'(cfg.failure_temperature) + TSUM_W'(cfg.cooling_rate);
    assign overheat  = TEMPERATURE_ENABLE && !short && (heat_sum > heat_lim);
    assign temp_norm = (heat_sum < TSUM_W'(cfg.cooling_rate)) ? '0
                     : TEMP_W'(heat_sum - TSUM_W'(cfg.cooling_rate));
    assign temp_cool = (temp_reg < cfg.cooling_rate) ? '0 : temp_reg - cfg.cooling_rate;

    always_comb begin
        if (!TEMPERATURE_ENABLE || short) begin
            temp_new = temp_reg;
        end else if (overheat) begin
            temp_new = temp_cool;
        end else begin
            temp_new = temp_norm;
        end
        if (short) begin
            fault = FAULT_ENERGY;
        end else if (overheat) begin
            fault = FAULT_HEAT;
        end else begin
            fault = FAULT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            temp_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        amag_reg   <= amag;
                        trq_reg    <= torque_in;
                        energy_reg <= energy_in;
                        state_reg  <= P_MUL;
                    end
                end
                P_MUL: begin
                    use_reg   <= ENERGY_W'(use_full >> 16);
                    rise_reg  <= TORQUE_W'(rise_full >> 16);
                    state_reg <= P_EVAL;
                end
                P_EVAL: begin
                    temp_reg           <= temp_new;
                    res_reg.torque     <= (fault == FAULT_NONE) ? trq_reg : '0;
                    res_reg.energy_out <= short ? energy_reg : energy_reg - use_reg;
                    res_reg.temp       <= temp_new;
                    res_reg.fault      <= fault;
                    done_reg           <= 1'b1;
                    state_reg          <= P_IDLE;
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
